>>> src/krt_pkg.sv
// Shared types, codes and sizes for the keyed record table.
`timescale 1ns / 1ps

package krt_pkg;

	// Default table depth
	localparam int unsigned ENTRIES_DEF = 16;

	// Fixed widths of the result fields
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned COUNT_W = 5;

	// Function codes of an input word
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// Result status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_STALE     = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	// One stored record
	typedef struct packed {
		logic        [15:0] key;
		logic        [7:0]  kind;
		logic signed [31:0] request;
		logic signed [31:0] reading;
	} record_t;

endpackage

>>> src/keyed_record_table_stale_filter_core.sv
// Last-value record table keyed by sender, with stale request filtering.
`timescale 1ns / 1ps

// Table of the latest record per sender key, held in one synchronous memory.
// A word is taken when start is high and busy is low; its result appears on the
// result ports for a single cycle with done high, and must be captured then.
// Update and lookup scan the valid entries in slot order through the single
// memory read port, one entry per cycle, and stop at the first slot that holds
// the key or after the last valid entry. Read by slot index and unused function
// codes go straight to the read state without a scan. A new word may be started
// in the cycle its predecessor's result is shown. Entries are written only on
// insert or newer update; no entry at or above the entry count is used, so the
// memory needs no clearing after reset.
module keyed_record_table_stale_filter_core #(
	parameter int unsigned ENTRIES = krt_pkg::ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [15:0]        key,
	input  logic [7:0]         board_kind,
	input  logic signed [31:0] request_number,
	input  logic signed [31:0] reading,
	input  logic [3:0]         read_index,
	output logic               done,
	output logic [2:0]         status,
	output logic [3:0]         slot,
	output logic [15:0]        out_key,
	output logic [7:0]         out_kind,
	output logic signed [31:0] out_request,
	output logic signed [31:0] out_reading,
	output logic [4:0]         entry_count
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ
	} state_t;

	state_t                   state_q;
	logic [1:0]               func_q;
	krt_pkg::record_t         new_q;
	logic [CW-1:0]            fill_q;
	logic [CW-1:0]            ptr_q;
	logic                     chk_q;
	logic [IW-1:0]            chk_slot_q;
	logic                     done_q;
	krt_pkg::status_t         status_q;
	logic [IW-1:0]            slot_q;
	krt_pkg::record_t         res_q;

	krt_pkg::record_t         rec_mem [ENTRIES];
	krt_pkg::record_t         rdata_q;

	logic [IW-1:0]            rd_addr;
	logic                     we;
	logic [IW-1:0]            wr_addr;
	logic                     hit;
	logic                     newer;
	logic                     full;

	// Compare the word under test against the entry just read
	assign hit   = chk_q && (rdata_q.key == new_q.key);
	assign newer = new_q.request > rdata_q.request;
	assign full  = (fill_q == CW'(ENTRIES));

	// Drive memory address and write enable
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = chk_slot_q;
		case (state_q)
			S_IDLE: begin
				if (start && func == krt_pkg::FUNC_READ) begin
					rd_addr = IW'(read_index);
				end
			end
			S_SCAN: begin
				rd_addr = IW'(ptr_q);
				if (func_q == krt_pkg::FUNC_UPDATE) begin
					if (hit && newer) begin
						we = 1'b1;
					end else if (!chk_q && !full) begin
						we      = 1'b1;
						wr_addr = IW'(fill_q);
					end
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// Record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			rec_mem[wr_addr] <= new_q;
		end
		rdata_q <= rec_mem[rd_addr];
	end

	// Sequence the scan and register the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			ptr_q      <= '0;
			chk_q      <= 1'b0;
			chk_slot_q <= '0;
			done_q     <= 1'b0;
			func_q     <= '0;
			status_q   <= krt_pkg::ST_NOT_FOUND;
			slot_q     <= '0;
			res_q      <= '0;
			new_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						new_q   <= '{key: key, kind: board_kind,
							request: request_number, reading: reading};
						ptr_q   <= CW'(1);
						if (func == krt_pkg::FUNC_READ) begin
							chk_q      <= (32'(read_index) < 32'(fill_q));
							chk_slot_q <= IW'(read_index);
							state_q    <= S_READ;
						end else if (func == krt_pkg::FUNC_UPDATE ||
							func == krt_pkg::FUNC_LOOKUP) begin
							chk_q      <= (fill_q != '0);
							chk_slot_q <= '0;
							state_q    <= S_SCAN;
						end else begin
							chk_q      <= 1'b0;
							chk_slot_q <= '0;
							state_q    <= S_READ;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						// Key present: lookup reports it found; update writes if newer, else drops as stale
						done_q  <= 1'b1;
						slot_q  <= chk_slot_q;
						state_q <= S_IDLE;
						if (func_q == krt_pkg::FUNC_LOOKUP) begin
							status_q <= krt_pkg::ST_FOUND;
							res_q    <= rdata_q;
						end else if (newer) begin
							status_q <= krt_pkg::ST_UPDATED;
							res_q    <= new_q;
						end else begin
							status_q <= krt_pkg::ST_STALE;
							res_q    <= rdata_q;
						end
					end else if (!chk_q) begin
						// Key absent: lookup reports not found; update appends, or refuses when full
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (func_q == krt_pkg::FUNC_LOOKUP) begin
							status_q <= krt_pkg::ST_NOT_FOUND;
							slot_q   <= '0;
							res_q    <= '0;
						end else if (full) begin
							status_q <= krt_pkg::ST_FULL;
							slot_q   <= '0;
							res_q    <= '0;
						end else begin
							status_q <= krt_pkg::ST_INSERTED;
							slot_q   <= IW'(fill_q);
							res_q    <= new_q;
							fill_q   <= fill_q + CW'(1);
						end
					end else begin
						// Advance to the next entry
						chk_q      <= (ptr_q < fill_q);
						chk_slot_q <= IW'(ptr_q);
						ptr_q      <= ptr_q + CW'(1);
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (chk_q) begin
						status_q <= krt_pkg::ST_FOUND;
						slot_q   <= chk_slot_q;
						res_q    <= rdata_q;
					end else begin
						status_q <= krt_pkg::ST_NOT_FOUND;
						slot_q   <= '0;
						res_q    <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign slot        = krt_pkg::SLOT_W'(slot_q);
	assign out_key     = res_q.key;
	assign out_kind    = res_q.kind;
	assign out_request = res_q.request;
	assign out_reading = res_q.reading;
	assign entry_count = krt_pkg::COUNT_W'(fill_q);

	// Check sequencing and table bookkeeping
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= ENTRIES)
		else $error("entry count beyond table depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == krt_pkg::ST_FULL |-> full)
		else $error("table full reported below capacity");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == krt_pkg::ST_INSERTED |-> fill_q == $past(fill_q) + CW'(1))
		else $error("insert did not grow the entry count");

endmodule

>>> test/keyed_record_table_stale_filter_core_tb.sv
// Self-checking testbench for the keyed record table with stale request filtering.
`timescale 1ns / 1ps

module keyed_record_table_stale_filter_core_tb;

	localparam int unsigned N_ENTRIES   = krt_pkg::ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Function code that the block leaves unused
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// One predicted answer of the table
	typedef struct packed {
		krt_pkg::status_t st;
		logic [3:0]       slot;
		krt_pkg::record_t rec;
		logic [4:0]       count;
	} table_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         func = krt_pkg::FUNC_UPDATE;
	logic [15:0]        key = '0;
	logic [7:0]         board_kind = '0;
	logic signed [31:0] request_number = '0;
	logic signed [31:0] reading = '0;
	logic [3:0]         read_index = '0;
	logic               done;
	logic [2:0]         status;
	logic [3:0]         slot;
	logic [15:0]        out_key;
	logic [7:0]         out_kind;
	logic signed [31:0] out_request;
	logic signed [31:0] out_reading;
	logic [4:0]         entry_count;

	// Shadow copy of the table and the answers still owed by the block
	krt_pkg::record_t shadow_table [N_ENTRIES];
	int unsigned      shadow_fill = 0;
	table_answer_t    answer_q [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;

	keyed_record_table_stale_filter_core #(
		.ENTRIES(N_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.key(key),
		.board_kind(board_kind),
		.request_number(request_number),
		.reading(reading),
		.read_index(read_index),
		.done(done),
		.status(status),
		.slot(slot),
		.out_key(out_key),
		.out_kind(out_kind),
		.out_request(out_request),
		.out_reading(out_reading),
		.entry_count(entry_count)
	);

	// Free-running clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding",
				cycle_count, answer_q.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		begin
			$display("%0t ns mismatch on %s: got %h, want %h", $realtime, what, got, want);
			mismatch_count++;
		end
	endtask

	// Lowest valid slot holding the key, or -1 when absent
	function automatic int find_slot(input logic [15:0] k);
		for (int i = 0; i < int'(shadow_fill); i++)
			if (shadow_table[i].key == k)
				return i;
		return -1;
	endfunction

	// Work out the answer to one word and advance the shadow table
	function automatic table_answer_t predict_answer(input logic [1:0] f,
			input logic [15:0] k, input logic [7:0] kind, input logic signed [31:0] req,
			input logic signed [31:0] rd, input logic [3:0] idx);
		table_answer_t a;
		int hit;
		a = '0;
		a.st = krt_pkg::ST_NOT_FOUND;
		hit = -1;
		case (f)
			krt_pkg::FUNC_UPDATE: begin
				hit = find_slot(k);
				if (hit < 0) begin
					if (shadow_fill >= N_ENTRIES) begin
						a.st = krt_pkg::ST_FULL;
					end else begin
						hit = int'(shadow_fill);
						shadow_table[hit] = '{key: k, kind: kind, request: req, reading: rd};
						shadow_fill++;
						a.st = krt_pkg::ST_INSERTED;
					end
				end else if (req > shadow_table[hit].request) begin
					shadow_table[hit] = '{key: k, kind: kind, request: req, reading: rd};
					a.st = krt_pkg::ST_UPDATED;
				end else begin
					a.st = krt_pkg::ST_STALE;
				end
			end
			krt_pkg::FUNC_LOOKUP: begin
				hit = find_slot(k);
				if (hit >= 0)
					a.st = krt_pkg::ST_FOUND;
			end
			krt_pkg::FUNC_READ: begin
				if (32'(idx) < shadow_fill) begin
					hit = int'(idx);
					a.st = krt_pkg::ST_FOUND;
				end
			end
			default: ;
		endcase
		// Entry fields stay zero for full and not found
		if (a.st != krt_pkg::ST_FULL && a.st != krt_pkg::ST_NOT_FOUND) begin
			a.slot = 4'(hit);
			a.rec = shadow_table[hit];
		end
		a.count = 5'(shadow_fill);
		return a;
	endfunction

	// Drive one word, hold it until taken, then record its answer
	task automatic send_word(input logic [1:0] f, input logic [15:0] k,
			input logic [7:0] kind, input logic signed [31:0] req,
			input logic signed [31:0] rd, input logic [3:0] idx);
		table_answer_t owed;
		begin
			start <= 1'b1;
			func <= f;
			key <= k;
			board_kind <= kind;
			request_number <= req;
			reading <= rd;
			read_index <= idx;
			do
				@(posedge clk);
			while (busy);
			owed = predict_answer(f, k, kind, req, rd, idx);
			answer_q.insert(answer_q.size(), owed);
		end
	endtask

	// Send in bursts of random length, with a random gap before most bursts
	task automatic pace_sender;
		begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 12);
				if ($urandom_range(3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 24)) @(posedge clk);
				end
			end
			burst_left--;
		end
	endtask

	// Hold off until every owed answer has come back
	task automatic drain_table;
		begin
			start <= 1'b0;
			@(posedge clk);
			while (answer_q.size() != 0)
				@(posedge clk);
		end
	endtask

	// A key that the table does not hold yet
	function automatic logic [15:0] fresh_key;
		logic [15:0] k;
		k = 16'($urandom);
		while (find_slot(k) >= 0)
			k = 16'($urandom);
		return k;
	endfunction

	// One random word: mostly known keys with plausible request numbers
	task automatic send_random_word(input int unsigned fresh_pct);
		int unsigned pick;
		int unsigned roll;
		int hit;
		logic [1:0] f;
		logic [15:0] k;
		logic signed [31:0] req;
		begin
			pick = $urandom_range(99);
			if (pick < 50)
				f = krt_pkg::FUNC_UPDATE;
			else if (pick < 75)
				f = krt_pkg::FUNC_LOOKUP;
			else if (pick < 95)
				f = krt_pkg::FUNC_READ;
			else
				f = FUNC_UNUSED;
			if (shadow_fill == 0 || $urandom_range(99) < fresh_pct)
				k = 16'($urandom);
			else
				k = shadow_table[$urandom_range(shadow_fill - 1)].key;
			hit = find_slot(k);
			roll = $urandom_range(99);
			if (hit < 0 || roll >= 85)
				req = $urandom;
			else if (roll < 55)
				req = shadow_table[hit].request + $urandom_range(1, 1000);
			else if (roll < 70)
				req = shadow_table[hit].request - $urandom_range(1, 1000);
			else
				req = shadow_table[hit].request;
			send_word(f, k, 8'($urandom), req, $urandom, 4'($urandom));
			pace_sender();
		end
	endtask

	// Empty-table answers, field extremes, stale and newer updates, reads
	task automatic test_directed;
		begin
			send_word(krt_pkg::FUNC_LOOKUP, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd0);
			send_word(krt_pkg::FUNC_READ, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd0);
			send_word(FUNC_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
			send_word(krt_pkg::FUNC_UPDATE, 16'h0000, 8'h00, 32'h8000_0000, 32'h8000_0000,
				4'h0);
			send_word(krt_pkg::FUNC_UPDATE, 16'hFFFF, 8'hFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				4'hF);
			// equal request is stale, one more is newer
			send_word(krt_pkg::FUNC_UPDATE, 16'h0000, 8'h11, 32'h8000_0000, 32'sd7, 4'h0);
			send_word(krt_pkg::FUNC_UPDATE, 16'h0000, 8'h5A, 32'h8000_0001, 32'sd1, 4'h0);
			send_word(krt_pkg::FUNC_UPDATE, 16'hFFFF, 8'h00, 32'h7FFF_FFFF, 32'sd0, 4'h0);
			send_word(krt_pkg::FUNC_UPDATE, 16'hFFFF, 8'h00, 32'h8000_0000, 32'sd0, 4'h0);
			// newer across the sign boundary, then an older one
			send_word(krt_pkg::FUNC_UPDATE, 16'h8000, 8'hA5, -32'sd1, 32'h0001_0000, 4'h5);
			send_word(krt_pkg::FUNC_UPDATE, 16'h8000, 8'h3C, 32'sd0, 32'hFFFF_8000, 4'hA);
			send_word(krt_pkg::FUNC_UPDATE, 16'h8000, 8'hC3, -32'sd5, 32'sd3, 4'h0);
			send_word(krt_pkg::FUNC_LOOKUP, 16'hFFFF, 8'h00, 32'sd0, 32'sd0, 4'h0);
			send_word(krt_pkg::FUNC_LOOKUP, 16'h1234, 8'h00, 32'sd0, 32'sd0, 4'h0);
			// reads below and beyond the count
			send_word(krt_pkg::FUNC_READ, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd1);
			send_word(krt_pkg::FUNC_READ, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd2);
			send_word(krt_pkg::FUNC_READ, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd3);
			send_word(krt_pkg::FUNC_READ, 16'hFFFF, 8'hFF, 32'sd0, 32'sd0, 4'd15);
			drain_table();
		end
	endtask

	// Mixed traffic while the table fills up
	task automatic test_growth;
		begin
			for (int n = 0; n < 150; n++)
				send_random_word(30);
			drain_table();
		end
	endtask

	// Fill every slot, then refuse new keys
	task automatic test_table_full;
		begin
			while (shadow_fill < N_ENTRIES) begin
				send_word(krt_pkg::FUNC_UPDATE, fresh_key(), 8'($urandom), $urandom,
					$urandom, 4'($urandom));
				pace_sender();
			end
			repeat (3) begin
				send_word(krt_pkg::FUNC_UPDATE, fresh_key(), 8'($urandom), $urandom,
					$urandom, 4'($urandom));
				pace_sender();
			end
			send_word(krt_pkg::FUNC_LOOKUP, fresh_key(), 8'h00, 32'sd0, 32'sd0, 4'd0);
			send_word(krt_pkg::FUNC_READ, 16'h0000, 8'h00, 32'sd0, 32'sd0, 4'd15);
			drain_table();
		end
	endtask

	// Long random run on the full table
	task automatic test_random_full;
		begin
			for (int n = 0; n < 260; n++)
				send_random_word(10);
			drain_table();
		end
	endtask

	// Compare each strobed answer with the oldest one owed
	always @(posedge clk) begin
		table_answer_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				report_mismatch("answer with nothing owed", 32'(status), '0);
			end else begin
				want = answer_q.pop_front();
				if (status !== want.st)
					report_mismatch("status", 32'(status), 32'(want.st));
				if (slot !== want.slot)
					report_mismatch("slot", 32'(slot), 32'(want.slot));
				if (out_key !== want.rec.key)
					report_mismatch("out_key", 32'(out_key), 32'(want.rec.key));
				if (out_kind !== want.rec.kind)
					report_mismatch("out_kind", 32'(out_kind), 32'(want.rec.kind));
				if (out_request !== want.rec.request)
					report_mismatch("out_request", out_request, want.rec.request);
				if (out_reading !== want.rec.reading)
					report_mismatch("out_reading", out_reading, want.rec.reading);
				if (entry_count !== want.count)
					report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
			end
		end
	end

	// Reset once, run the tests in turn, then settle and judge
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_growth();
		test_table_full();
		test_random_full();
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (N_ENTRIES + 6) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
